@@ design/klt_pkg.sv @@
// ----------------------------------------------------------------------------
// klt_pkg
// shared types and constants for the kth-largest threshold block
// ----------------------------------------------------------------------------
package klt_pkg;

    localparam int MAX_KEEP_DEFAULT = 256;
    localparam int DATA_W           = 32;
    localparam int KEEP_W           = 9;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     last_item;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] threshold_value;
        logic [KEEP_W-1:0]        kept_total;
    } out_beat_t;

endpackage

@@ design/kth_largest_threshold_top.sv @@
// ----------------------------------------------------------------------------
// kth_largest_threshold_top
// streaming top-k selection: min-heap of the largest values, threshold per pass
// ----------------------------------------------------------------------------
//  channel   | signals                          | beat
//  ----------+----------------------------------+------------------------------
//  input     | in_valid / in_ready / in_beat    | sample_value, last_item
//  output    | out_valid / out_ready / out_beat | threshold_value, kept_total
//  config    | cfg_wr_en / cfg_wr_data          | keep_count (9 bits)
//
//  one input beat at a time; a beat is done in the accepting cycle when it is dropped,
//  fills an empty heap or replaces the root of a heap of one, otherwise it sifts
//  one heap level per cycle through the single write port of the heap memory
//  a last beat then passes through the emit state, which loads the result register
//  reset clears the keep count, sequencer state, fill count and result valid only
//  a last beat waits while the result register is full, stalling the input
// ----------------------------------------------------------------------------
module kth_largest_threshold_top #(
    parameter int MAX_KEEP = klt_pkg::MAX_KEEP_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  klt_pkg::in_beat_t          in_beat,
    output logic                       out_valid,
    input  logic                       out_ready,
    output klt_pkg::out_beat_t         out_beat,
    input  logic                       cfg_wr_en,
    input  logic [klt_pkg::KEEP_W-1:0] cfg_wr_data
);

    // keep count register, reset to one
    logic [klt_pkg::KEEP_W-1:0] keep_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= klt_pkg::KEEP_W'(1);
        end
        else if (cfg_wr_en)
        begin
            keep_count_reg <= cfg_wr_data;
        end
    end

    // heap sequencer with its memory and the result register
    klt_ctrl #(.MAX_KEEP(MAX_KEEP)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .keep_count (keep_count_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_beat    (in_beat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_beat   (out_beat)
    );

endmodule

@@ design/klt_heap_mem.sv @@
// ----------------------------------------------------------------------------
// klt_heap_mem
// heap store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module klt_heap_mem #(
    parameter int AW = 8,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr0,
    input  logic [AW-1:0] raddr1,
    output logic [DW-1:0] rdata0,
    output logic [DW-1:0] rdata1
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

@@ design/klt_ctrl.sv @@
// ----------------------------------------------------------------------------
// klt_ctrl
// min-heap sequencer: sift-up on insert, sift-down on root replace, result out
// ----------------------------------------------------------------------------
module klt_ctrl #(
    parameter int MAX_KEEP = klt_pkg::MAX_KEEP_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [klt_pkg::KEEP_W-1:0]   keep_count,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  klt_pkg::in_beat_t            in_beat,
    output logic                         out_valid,
    input  logic                         out_ready,
    output klt_pkg::out_beat_t           out_beat
);

    localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int PW = CW + 2;
    localparam int KW = (CW > klt_pkg::KEEP_W) ? CW : klt_pkg::KEEP_W;
    localparam int DW = klt_pkg::DATA_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UP   = 5'b00010,
        S_DOWN = 5'b00100,
        S_PUT  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic signed [DW-1:0]  x_reg, x_next;
    logic                  last_reg, last_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic signed [DW-1:0]  root_reg, root_next;
    logic                  out_valid_reg, out_valid_next;
    klt_pkg::out_beat_t    out_beat_reg, out_beat_next;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic signed [DW-1:0]  wdata;
    logic [AW-1:0]         raddr0, raddr1;
    logic [DW-1:0]         rdata0, rdata1;

    logic [KW-1:0]         keep_ext, k_eff;
    logic                  accept, done;
    logic [PW-1:0]         lch, rch, nl, cpos;
    logic signed [DW-1:0]  cdata;
    logic [AW-1:0]         parent;

    klt_heap_mem #(.AW(AW), .DW(DW)) u_mem (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    assign keep_ext = KW'(keep_count);
    assign k_eff    = (keep_ext == '0) ? KW'(1) :
                      (keep_ext > KW'(MAX_KEEP)) ? KW'(MAX_KEEP) : keep_ext;
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign parent   = AW'((pos_reg - AW'(1)) >> 1);

    // children of the current hole, and the smaller one
    assign lch   = PW'({pos_reg, 1'b0}) + PW'(1);
    assign rch   = lch + PW'(1);
    always_comb
    begin
        if ((rch < PW'(cnt_reg)) && ($signed(rdata1) < $signed(rdata0)))
        begin
            cpos  = rch;
            cdata = $signed(rdata1);
        end
        else
        begin
            cpos  = lch;
            cdata = $signed(rdata0);
        end
    end
    assign nl = {cpos[PW-2:0], 1'b0} + PW'(1);

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        last_next      = last_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        root_next      = root_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_beat_next  = out_beat_reg;
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = x_reg;
        raddr0         = parent;
        raddr1         = parent;
        done           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_next    = in_beat.sample_value;
                    last_next = in_beat.last_item;
                    wdata     = in_beat.sample_value;
                    if (KW'(cnt_reg) < k_eff)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                        if (cnt_reg == '0)
                        begin
                            we        = 1'b1;
                            waddr     = '0;
                            root_next = in_beat.sample_value;
                            done      = 1'b1;
                        end
                        else
                        begin
                            pos_next   = AW'(cnt_reg);
                            raddr0     = AW'((cnt_reg - CW'(1)) >> 1);
                            state_next = S_UP;
                        end
                    end
                    else if (in_beat.sample_value > root_reg)
                    begin
                        pos_next = '0;
                        if (cnt_reg == CW'(1))
                        begin
                            we        = 1'b1;
                            waddr     = '0;
                            root_next = in_beat.sample_value;
                            done      = 1'b1;
                        end
                        else
                        begin
                            raddr0     = AW'(1);
                            raddr1     = AW'(2);
                            state_next = S_DOWN;
                        end
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
            end
            S_UP:
            begin
                we = 1'b1;
                if ($signed(rdata0) > x_reg)
                begin
                    // move parent down into the hole
                    wdata    = $signed(rdata0);
                    pos_next = parent;
                    raddr0   = AW'((parent - AW'(1)) >> 1);
                    if (parent == '0)
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    done = 1'b1;
                end
            end
            S_DOWN:
            begin
                we = 1'b1;
                if (cdata < x_reg)
                begin
                    // move smaller child up into the hole
                    wdata    = cdata;
                    pos_next = AW'(cpos);
                    raddr0   = AW'(nl);
                    raddr1   = AW'(nl + PW'(1));
                    if (pos_reg == '0)
                    begin
                        root_next = cdata;
                    end
                    if (nl >= PW'(cnt_reg))
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    if (pos_reg == '0)
                    begin
                        root_next = x_reg;
                    end
                    done = 1'b1;
                end
            end
            S_PUT:
            begin
                we = 1'b1;
                if (pos_reg == '0)
                begin
                    root_next = x_reg;
                end
                done = 1'b1;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_beat_next.threshold_value = root_reg;
                    out_beat_next.kept_total      = klt_pkg::KEEP_W'(cnt_reg);
                    cnt_next       = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done)
        begin
            state_next = (state_reg == S_IDLE ? in_beat.last_item : last_reg) ?
                         S_EMIT : S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        last_reg     <= last_next;
        pos_reg      <= pos_next;
        root_reg     <= root_next;
        out_beat_reg <= out_beat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        KW'(cnt_reg) <= KW'(MAX_KEEP))
        else $error("heap count above capacity");

    a_hole_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP || state_reg == S_DOWN || state_reg == S_PUT)
        |-> (CW'(pos_reg) < cnt_reg))
        else $error("hole outside filled heap");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && (!out_valid_reg || out_ready))
        |=> (cnt_reg == '0 && out_valid_reg))
        else $error("result not loaded or count not cleared");

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("ready while heap busy");

endmodule

@@ test/kth_largest_threshold_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kth_largest_threshold_top_tb
// drives passes of signed values into the top-k threshold block with random
// gaps and stalls, predicts each pass threshold and kept count, and compares
// every output beat with the oldest prediction
// ----------------------------------------------------------------------------

// scoreboard: its own copy of keep count and kept values, a queue of thresholds
class klt_threshold_board;
    logic [8:0]          keep_reg;
    logic signed [31:0]  kept[$];
    klt_pkg::out_beat_t  pending[$];
    int                  errors;

    function new();
        keep_reg = 9'd1;
        errors   = 0;
    endfunction

    function int min_slot();
        int best;
        best = 0;
        for (int i = 1; i < kept.size(); i++)
            if (kept[i] < kept[best])
                best = i;
        return best;
    endfunction

    function void note_sample(klt_pkg::in_beat_t b);
        int lim;
        int m;
        klt_pkg::out_beat_t r;
        lim = (keep_reg == 0) ? 1 : keep_reg;
        if (lim > 256)
            lim = 256;
        if (kept.size() < lim)
            kept.push_back(b.sample_value);
        else
        begin
            m = min_slot();
            if (kept[m] < b.sample_value)
                kept[m] = b.sample_value;
        end
        if (b.last_item)
        begin
            r.threshold_value = kept[min_slot()];
            r.kept_total      = 9'(kept.size());
            pending.push_back(r);
            kept.delete();
        end
    endfunction

    function void check_result(klt_pkg::out_beat_t got);
        klt_pkg::out_beat_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected beat threshold_value %0d", got.threshold_value);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.threshold_value !== e.threshold_value)
        begin
            $error("threshold_value expected %0d actual %0d",
                   e.threshold_value, got.threshold_value);
            errors++;
        end
        if (got.kept_total !== e.kept_total)
        begin
            $error("kept_total expected %0d actual %0d", e.kept_total, got.kept_total);
            errors++;
        end
    endfunction
endclass

module kth_largest_threshold_top_tb;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    klt_pkg::in_beat_t   in_beat;
    logic                out_valid;
    logic                out_ready;
    klt_pkg::out_beat_t  out_beat;
    logic                cfg_wr_en;
    logic [8:0]          cfg_wr_data;

    klt_threshold_board board;
    bit  hold_sink;     // long receiver hold-off request
    bit  sink_hold_done;

    kth_largest_threshold_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_beat     (in_beat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_beat    (out_beat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // random value, biased toward extremes and small ranges so ties happen
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(0, 7))) - 4;
            default: return $urandom;
        endcase
    endfunction

    // one beat on the input channel, with an optional random gap first; valid stays high
    // after the beat so back-to-back beats need no second drive in one step
    task automatic send_sample(input logic signed [31:0] v, input bit last, input bit gap);
        int idle;
        idle = gap ? $urandom_range(0, 4) : 0;
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{sample_value: v, last_item: last};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_sample('{sample_value: v, last_item: last});
    endtask

    // drop valid, wait for drain, then settle the heap before a register write
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_keep(input logic [8:0] k);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        board.keep_reg = k;
    endtask

    // a pass of n values; the last one carries the mark
    task automatic send_pass(input int n, input bit gap);
        for (int i = 0; i < n; i++)
            send_sample(pick_value(), i == n - 1, gap);
    endtask

    // receiver: random idle cycles per beat, plus one long hold-off on request
    initial
    begin
        int idle;
        out_ready = 1'b0;
        sink_hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_sink && !sink_hold_done)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                sink_hold_done = 1'b1;
            end
            else
            begin
                idle = $urandom_range(0, 4);
                if (idle > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (idle) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            board.check_result(out_beat);
        end
    end

    // stimulus
    initial
    begin
        int n;
        logic [8:0] keeps[6];
        board       = new();
        hold_sink   = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_beat     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset keep of one, single-beat pass, extremes
        send_sample(32'sh80000000, 1'b1, 1'b0);
        send_sample(32'sh7fffffff, 1'b1, 1'b0);
        send_sample(32'sh0, 1'b0, 1'b0);
        send_sample(-32'sd5, 1'b1, 1'b0);
        // keep of three: ties, fewer items than keep, full then replace
        write_keep(9'd3);
        send_sample(32'sd5, 1'b0, 1'b0);
        send_sample(32'sd5, 1'b1, 1'b0);
        send_sample(32'sd1, 1'b0, 1'b0);
        send_sample(32'sd2, 1'b0, 1'b0);
        send_sample(32'sd3, 1'b0, 1'b0);
        send_sample(32'sd3, 1'b0, 1'b0);
        send_sample(32'sd9, 1'b0, 1'b0);
        send_sample(-32'sd1, 1'b1, 1'b0);
        // zero acts as one, above the max acts as the max
        write_keep(9'd0);
        send_sample(32'sd4, 1'b0, 1'b0);
        send_sample(32'sd7, 1'b1, 1'b0);
        write_keep(9'd511);
        send_pass(4, 1'b0);
        // keep changed mid-pass: store does not shrink
        write_keep(9'd4);
        send_pass(3, 1'b0);
        wait_drained();
        send_sample(32'sd10, 1'b0, 1'b0);
        send_sample(32'sd20, 1'b0, 1'b0);
        send_sample(32'sd30, 1'b0, 1'b0);
        write_keep(9'd2);
        send_sample(32'sd15, 1'b0, 1'b0);
        send_sample(32'sd40, 1'b1, 1'b0);

        // full-size pass at the largest keep, then replacements at full
        write_keep(9'd256);
        send_pass(270, 1'b1);

        // random phases, mostly small keep counts and short passes
        keeps = '{9'd1, 9'd2, 9'd5, 9'd17, 9'd256, 9'd0};
        n = 0;
        while (n < 80)
        begin
            write_keep($urandom_range(0, 3) == 0 ? keeps[$urandom_range(0, 5)]
                                                 : 9'($urandom_range(1, 12)));
            for (int p = 0; p < 6; p++)
            begin
                int len;
                len = $urandom_range(1, 16);
                // sometimes no gaps at all
                send_pass(len, $urandom_range(0, 2) != 0);
                n += len;
            end
            // long receiver hold-off while the sender keeps offering
            if (!hold_sink)
            begin
                hold_sink = 1'b1;
                for (int p = 0; p < 10; p++)
                    send_pass($urandom_range(1, 3), 1'b0);
            end
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // time limit
    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
